/* design/f24si_pkg.sv */
// Shared types and constants for the 24-bit float to scaled integer converter.
package f24si_pkg;

   localparam int EXP_BIAS  = 16;
   localparam int KEEP_BITS = 24;
   localparam int MAG_W     = 16;
   localparam int PROD_W    = 31;
   localparam int ROUND_W   = 32;
   localparam int WIDE_W    = 64;
   localparam int EXP_W     = 8;
   localparam int DROP_W    = 3;
   localparam int MAX_LSHIFT = 32;

   localparam logic [ROUND_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [ROUND_W-1:0] NEG_LIMIT = 32'h8000_0000;

   // Fields of one incoming transaction.
   typedef struct packed {
      logic [7:0]         mant_low;
      logic [7:0]         mant_high;
      logic [7:0]         sign_exp;
      logic signed [15:0] scale;
   } req_type;

   // After the multiply: exact magnitude product, sign and unbiased exponent.
   typedef struct packed {
      logic                    neg;
      logic signed [EXP_W-1:0] expo;
      logic [PROD_W-1:0]       prod;
   } mult_type;

   // After rounding to 24 significant bits.
   typedef struct packed {
      logic                    neg;
      logic signed [EXP_W-1:0] expo;
      logic [ROUND_W-1:0]      mag;
   } round_type;

   // After the power-of-two scaling.
   typedef struct packed {
      logic              neg;
      logic              big;
      logic [WIDE_W-1:0] val;
   } shift_type;

   // Final result transaction.
   typedef struct packed {
      logic signed [31:0] result;
      logic               clipped;
   } rsp_type;

endpackage

/* design/f24si_mult.sv */
// Stage one: decode the sign and exponent and form the exact magnitude product.
module f24si_mult import f24si_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output mult_type out_data
);

   logic     valid_ff;
   mult_type data_ff;
   mult_type data_in;

   logic [MAG_W-1:0]   mag;
   logic [MAG_W-1:0]   sc_mag;
   logic [2*MAG_W-1:0] prod_full;

   always_comb begin
      mag       = {in_data.mant_high, in_data.mant_low};
      // The magnitude of -32768 is 0x8000, which still fits in 16 unsigned bits.
      sc_mag    = in_data.scale[15] ? MAG_W'(-in_data.scale) : MAG_W'(in_data.scale);
      prod_full = mag * sc_mag;
      data_in.neg  = in_data.sign_exp[7] ^ in_data.scale[15];
      data_in.expo = {in_data.sign_exp[6], in_data.sign_exp[6:0]} - EXP_W'(EXP_BIAS);
      data_in.prod = prod_full[PROD_W-1:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/f24si_round.sv */
// Stage two: round the product to 24 significant bits, nearest with ties to even.
module f24si_round import f24si_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  mult_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output round_type out_data
);

   localparam int EXTRA = PROD_W - KEEP_BITS;

   logic      valid_ff;
   round_type data_ff;
   round_type data_in;

   logic [DROP_W-1:0]  drop;
   logic [ROUND_W-1:0] p32;
   logic [ROUND_W-1:0] unit;
   logic [ROUND_W-1:0] mask;
   logic [ROUND_W-1:0] half;
   logic               rbit;
   logic               sticky;
   logic               lsb;
   logic               inc;

   always_comb begin
      // Number of bits beyond the 24 kept ones, from the leading one.
      drop = '0;
      for (int i = 0; i < EXTRA; i++) begin
         if (in_data.prod[KEEP_BITS+i]) begin
            drop = DROP_W'(i + 1);
         end
      end
      p32    = {{(ROUND_W-PROD_W){1'b0}}, in_data.prod};
      unit   = ROUND_W'(1) << drop;
      mask   = unit - ROUND_W'(1);
      half   = mask ^ (mask >> 1);
      rbit   = |(p32 & half);
      sticky = |(p32 & (mask >> 1));
      lsb    = |(p32 & unit);
      inc    = rbit && (sticky || lsb);
      data_in.neg  = in_data.neg;
      data_in.expo = in_data.expo;
      data_in.mag  = (p32 & ~mask) + (inc ? unit : '0);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/f24si_shift.sv */
// Stage three: scale the rounded magnitude by a power of two, dropping fraction bits.
module f24si_shift import f24si_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  round_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output shift_type out_data
);

   logic      valid_ff;
   shift_type data_ff;
   shift_type data_in;

   logic [EXP_W-1:0] rshift;

   always_comb begin
      rshift       = EXP_W'(-in_data.expo);
      data_in.neg  = in_data.neg;
      data_in.big  = 1'b0;
      data_in.val  = '0;
      if (in_data.mag == '0) begin
         data_in.val = '0;
      end else if (in_data.expo > EXP_W'(MAX_LSHIFT)) begin
         // Far beyond the output range: saturate whatever the magnitude.
         data_in.big = 1'b1;
      end else if (!in_data.expo[EXP_W-1]) begin
         data_in.val = {{(WIDE_W-ROUND_W){1'b0}}, in_data.mag} << in_data.expo[5:0];
      end else if (rshift < EXP_W'(ROUND_W)) begin
         data_in.val = {{(WIDE_W-ROUND_W){1'b0}}, in_data.mag >> rshift[4:0]};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/f24si_sat.sv */
// Stage four: apply the sign and saturate to the 32-bit signed range.
module f24si_sat import f24si_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  shift_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rsp_type   out_data
);

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   always_comb begin
      if (in_data.neg) begin
         if (in_data.big || in_data.val > {{(WIDE_W-ROUND_W){1'b0}}, NEG_LIMIT}) begin
            data_in.result  = NEG_LIMIT;
            data_in.clipped = 1'b1;
         end else begin
            data_in.result  = -in_data.val[ROUND_W-1:0];
            data_in.clipped = 1'b0;
         end
      end else begin
         if (in_data.big || in_data.val > {{(WIDE_W-ROUND_W){1'b0}}, POS_LIMIT}) begin
            data_in.result  = POS_LIMIT;
            data_in.clipped = 1'b1;
         end else begin
            data_in.result  = in_data.val[ROUND_W-1:0];
            data_in.clipped = 1'b0;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/float24_to_scaled_integer.sv */
// Top level of the 24-bit float to scaled 32-bit integer converter.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_ready   mant_low, mant_high, sign_exp, scale
//   rsp_      out         rsp_valid/rsp_ready   result, clipped
//
// There is one register stage each for multiply, round, shift and saturate. rsp_valid
// rises when a transaction has passed the multiply, round and shift registers. A new
// transaction may enter every cycle in which req_ready is high.
// Reset (synchronous, active high) clears only the stage valid bits.
// Each stage holds its transaction while the next one is full and stalled, and
// empty stages keep filling, so up to four transactions wait behind a stalled output.
// req_ready falls only when all four stages hold a transaction and rsp_ready is low.
module float24_to_scaled_integer import f24si_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_mant_low,
   input  logic [7:0]         req_mant_high,
   input  logic [7:0]         req_sign_exp,
   input  logic signed [15:0] req_scale,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_clipped
);

   req_type   req_data;
   mult_type  mult_data;
   round_type round_data;
   shift_type shift_data;
   rsp_type   rsp_data;

   logic mult_valid;
   logic mult_ready;
   logic round_valid;
   logic round_ready;
   logic shift_valid;
   logic shift_ready;

   always_comb begin
      req_data.mant_low  = req_mant_low;
      req_data.mant_high = req_mant_high;
      req_data.sign_exp  = req_sign_exp;
      req_data.scale     = req_scale;
   end

   // The exact product of the 16-bit magnitude and the scale magnitude.
   f24si_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (mult_valid),
      .out_ready (mult_ready),
      .out_data  (mult_data)
   );

   // Rounding to 24 significant bits, as a single-precision multiply would.
   f24si_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_ready  (mult_ready),
      .in_data   (mult_data),
      .out_valid (round_valid),
      .out_ready (round_ready),
      .out_data  (round_data)
   );

   // Power-of-two scaling by the unbiased exponent, truncating toward zero.
   f24si_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (round_valid),
      .in_ready  (round_ready),
      .in_data   (round_data),
      .out_valid (shift_valid),
      .out_ready (shift_ready),
      .out_data  (shift_data)
   );

   // Sign application and saturation; this stage is also the output register.
   f24si_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shift_valid),
      .in_ready  (shift_ready),
      .in_data   (shift_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_result  = rsp_data.result;
   assign rsp_clipped = rsp_data.clipped;

endmodule

/* design/f24si_checker.sv */
// Port-level checks for the converter, bound to its top level.
module f24si_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_mant_low,
   input logic [7:0]         req_mant_high,
   input logic [7:0]         req_sign_exp,
   input logic signed [15:0] req_scale,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_result,
   input logic               rsp_clipped
);

   // A waiting request transaction is held steady by the sender.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_mant_low)
         && $stable(req_mant_high) && $stable(req_sign_exp) && $stable(req_scale))
      else $error("request transaction changed while waiting");

   // A stalled result transaction stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_clipped))
      else $error("result transaction changed while stalled");

   // A saturated result sits exactly on one of the two limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_result == 32'sh7FFF_FFFF || rsp_result == 32'sh8000_0000)
      else $error("clipped result is not a range limit");

   // The input side only stalls while a result waits at a stalled output.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled while the output is free");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind float24_to_scaled_integer f24si_checker u_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the 24-bit float to scaled integer converter.
`timescale 1ns / 1ps

module tb;
   import f24si_pkg::*;

   // Sign bit values for the sign/exponent byte.
   localparam bit SIGN_POS = 1'b0;
   localparam bit SIGN_NEG = 1'b1;

   // Whether a directed row carries its expected result or takes it from the predictor.
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   localparam logic signed [15:0] SCALE_MIN = -16'sd32768;
   localparam logic signed [15:0] SCALE_MAX = 16'sd32767;

   localparam int RANDOM_ITEMS    = 1500;
   localparam int HOLDOFF_AT      = 300;   // transaction at which the receiver holds off
   localparam int HOLDOFF_CYCLES  = 64;
   localparam int PAUSE_AT        = 700;   // transaction before which the sender drains
   localparam int QUIET_FROM      = 900;   // stretch with no idling on either side
   localparam int QUIET_TO        = 1100;
   localparam int DRAIN_CYCLES    = 16;    // four pipeline stages, with a margin
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int REPORT_LIMIT    = 20;

   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } directed_case_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_mant_low = '0;
   logic [7:0]         req_mant_high = '0;
   logic [7:0]         req_sign_exp = '0;
   logic signed [15:0] req_scale = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_clipped;

   // Expected results, oldest first, one per accepted request transaction.
   rsp_type           pending_results[$];
   directed_case_type directed_cases[$];

   int mismatches      = 0;
   int results_seen    = 0;
   int holdoff_left    = 0;
   bit holdoff_request = 1'b0;
   bit quiet           = 1'b0;

   float24_to_scaled_integer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mant_low  (req_mant_low),
      .req_mant_high (req_mant_high),
      .req_sign_exp  (req_sign_exp),
      .req_scale     (req_scale),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .rsp_clipped   (rsp_clipped)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Builds the sign/exponent byte from a sign and a raw exponent in -64..63.
   function automatic logic [7:0] pack_sign_exp(input bit neg, input int expo);
      return {neg, 7'(expo)};
   endfunction

   // Computes the converted value: exact magnitude product, rounding to 24 significant
   // bits with ties to even, power-of-two scaling with truncation toward zero, and
   // saturation to the signed 32-bit range.
   function automatic rsp_type scaled_int_of(input req_type item);
      logic [63:0] magnitude;
      logic [63:0] factor;
      logic [63:0] product;
      logic [63:0] kept;
      logic [63:0] rest;
      logic [63:0] half;
      logic [63:0] scaled;
      logic        neg;
      int          expo;
      int          len;
      int          drop;
      rsp_type     conv;
      magnitude = {48'd0, item.mant_high, item.mant_low};
      neg       = item.sign_exp[7];
      expo      = {{25{item.sign_exp[6]}}, item.sign_exp[6:0]};
      expo      = expo - EXP_BIAS;
      if (item.scale < 0) begin
         factor = 64'(-int'(item.scale));
         neg    = ~neg;
      end else begin
         factor = 64'(int'(item.scale));
      end
      product = magnitude * factor;

      len = 0;
      for (int i = 0; i < 64; i++) begin
         if (product[i]) len = i + 1;
      end
      kept = product;
      if (len > KEEP_BITS) begin
         drop = len - KEEP_BITS;
         kept = product >> drop;
         rest = product & ((64'd1 << drop) - 64'd1);
         half = 64'd1 << (drop - 1);
         if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
         kept = kept << drop;
      end

      // Anything shifted left by more than 32 is far out of range; a right shift
      // of 64 or more leaves nothing.
      if (kept == 64'd0) begin
         scaled = 64'd0;
      end else if (expo >= 0) begin
         scaled = (expo > 32) ? (64'd1 << 40) : (kept << expo);
      end else begin
         scaled = (-expo >= 64) ? 64'd0 : (kept >> (-expo));
      end

      conv.clipped = 1'b0;
      if (neg) begin
         if (scaled > {32'd0, NEG_LIMIT}) begin
            scaled       = {32'd0, NEG_LIMIT};
            conv.clipped = 1'b1;
         end
         conv.result = ~scaled[31:0] + 32'd1;
      end else begin
         if (scaled > {32'd0, POS_LIMIT}) begin
            scaled       = {32'd0, POS_LIMIT};
            conv.clipped = 1'b1;
         end
         conv.result = scaled[31:0];
      end
      return conv;
   endfunction

   // Idle length for either side: mostly none, some short, a few long. Both sides
   // run without gaps in the quiet stretch and while the receiver holds off, so
   // that the sender keeps pressing against a full pipeline.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || holdoff_request || holdoff_left > 0) return 0;
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random request, biased towards magnitudes and scales at their extremes and
   // towards exponents where the result is neither zero nor saturated.
   function automatic req_type random_request();
      req_type item;
      int      expo;
      case ($urandom_range(0, 7))
         0:       {item.mant_high, item.mant_low} = 16'($urandom_range(0, 15));
         1:       {item.mant_high, item.mant_low} = 16'hFFFF - 16'($urandom_range(0, 3));
         2:       {item.mant_high, item.mant_low} = 16'd1 << $urandom_range(0, 15);
         default: {item.mant_high, item.mant_low} = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       expo = int'($urandom_range(0, 127)) - 64;
         1:       expo = int'($urandom_range(17, 50));
         default: expo = int'($urandom_range(0, 32)) - 16;
      endcase
      item.sign_exp = pack_sign_exp(1'($urandom), expo);
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0:       item.scale = SCALE_MIN;
               1:       item.scale = SCALE_MAX;
               2:       item.scale = 16'sd0;
               3:       item.scale = 16'sd1;
               default: item.scale = -16'sd1;
            endcase
         end
         1:       item.scale = 16'($urandom_range(0, 31)) - 16'd16;
         default: item.scale = 16'($urandom);
      endcase
      return item;
   endfunction

   task automatic add_case(input logic [15:0] magnitude, input logic [7:0] sign_exp,
                           input logic signed [15:0] scale, input bit typed,
                           input logic [31:0] result, input logic clipped);
      directed_case_type row;
      row.stim.mant_low   = magnitude[7:0];
      row.stim.mant_high  = magnitude[15:8];
      row.stim.sign_exp   = sign_exp;
      row.stim.scale      = scale;
      row.typed           = typed;
      row.want.result     = result;
      row.want.clipped    = clipped;
      directed_cases.push_back(row);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   // Presents one request transaction and holds it until it is accepted. The
   // expected result is queued at the edge at which the handshake completes.
   task automatic offer(input req_type item, input rsp_type want);
      req_valid     <= 1'b1;
      req_mant_low  <= item.mant_low;
      req_mant_high <= item.mant_high;
      req_sign_exp  <= item.sign_exp;
      req_scale     <= item.scale;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(want);
   endtask

   // Lowers valid for the given number of cycles; a zero gap keeps it high so that
   // the next transaction follows back to back.
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every queued result has been returned.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_result();
      rsp_type want;
      results_seen++;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h clipped %b", rsp_result, rsp_clipped));
         return;
      end
      want = pending_results.pop_front();
      if (rsp_result !== want.result)
         report_mismatch($sformatf("result %h, expected %h", rsp_result, want.result));
      if (rsp_clipped !== want.clipped)
         report_mismatch($sformatf("clipped %b, expected %b", rsp_clipped, want.clipped));
   endtask

   // Receiver: takes result transactions and checks them against the oldest
   // expectation. Ready is dropped for random gaps and, once, for a long hold-off
   // that is counted here, so that all four stages fill and req_ready falls.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result();
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoff_left    = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left  = pick_gap();
         end
      end
   end

   // Watchdog: ends the run when no transaction has moved on either channel for
   // too long. Every correct gap, stall and hold-off is far shorter than the limit.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** float24_to_scaled_integer: FAILED **");
      $finish;
   end

   initial begin : stimulus
      rsp_type want;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed cases. Results that can be read straight off the format are
      // written in; rounding and truncation cases are left to the predictor.
      // All zeros, a zero scale, and a zero magnitude with the largest negative scale.
      add_case(16'h0000, pack_sign_exp(SIGN_POS, 0),   16'sd0,    TYPED, 32'h0000_0000, 1'b0);
      add_case(16'hFFFF, pack_sign_exp(SIGN_NEG, 63),  16'sd0,    TYPED, 32'h0000_0000, 1'b0);
      add_case(16'h0000, pack_sign_exp(SIGN_NEG, 63),  SCALE_MIN, TYPED, 32'h0000_0000, 1'b0);
      // Largest magnitude, exponent and scale: saturation towards either sign.
      add_case(16'hFFFF, pack_sign_exp(SIGN_POS, 63),  SCALE_MAX, TYPED, 32'h7FFF_FFFF, 1'b1);
      add_case(16'hFFFF, pack_sign_exp(SIGN_NEG, 63),  SCALE_MAX, TYPED, 32'h8000_0000, 1'b1);
      add_case(16'hFFFF, pack_sign_exp(SIGN_POS, 63),  SCALE_MIN, TYPED, 32'h8000_0000, 1'b1);
      // Smallest exponent: everything is shifted out.
      add_case(16'hFFFF, pack_sign_exp(SIGN_NEG, -64), SCALE_MIN, TYPED, 32'h0000_0000, 1'b0);
      // Exactly minus two to the 31, reached through the sign bit and through the
      // scale, is not clipped; the same magnitude with a positive sign is.
      add_case(16'h8000, pack_sign_exp(SIGN_NEG, 18),  16'sd16384, TYPED, 32'h8000_0000, 1'b0);
      add_case(16'h8000, pack_sign_exp(SIGN_POS, 17),  SCALE_MIN,  TYPED, 32'h8000_0000, 1'b0);
      add_case(16'h8000, pack_sign_exp(SIGN_POS, 18),  16'sd16384, TYPED, 32'h7FFF_FFFF, 1'b1);
      // Minus one half truncates to zero, not to minus zero or minus one.
      add_case(16'h0001, pack_sign_exp(SIGN_NEG, 15),  16'sd1,  TYPED, 32'h0000_0000, 1'b0);
      add_case(16'h0001, pack_sign_exp(SIGN_POS, 16),  16'sd1,  TYPED, 32'h0000_0001, 1'b0);
      add_case(16'h0001, pack_sign_exp(SIGN_NEG, 16),  16'sd1,  TYPED, 32'hFFFF_FFFF, 1'b0);
      add_case(16'h0001, pack_sign_exp(SIGN_POS, 16),  -16'sd1, TYPED, 32'hFFFF_FFFF, 1'b0);
      // Left shifts of 30, 32 and 33 places: the last two leave the range.
      add_case(16'h0001, pack_sign_exp(SIGN_POS, 46),  16'sd1,  TYPED, 32'h4000_0000, 1'b0);
      add_case(16'h0001, pack_sign_exp(SIGN_POS, 48),  16'sd1,  TYPED, 32'h7FFF_FFFF, 1'b1);
      add_case(16'h0001, pack_sign_exp(SIGN_NEG, 49),  16'sd1,  TYPED, 32'h8000_0000, 1'b1);
      // A 31-bit product that needs rounding, then the same pushed over the top.
      add_case(16'hFFFF, pack_sign_exp(SIGN_POS, 16),  SCALE_MAX, PREDICTED, '0, 1'b0);
      add_case(16'hFFFF, pack_sign_exp(SIGN_POS, 17),  SCALE_MAX, PREDICTED, '0, 1'b0);
      // Ties: 2^24 + 1 stays on the even value, 2 * 65535 * 257 rounds up to even.
      add_case(16'hFF01, pack_sign_exp(SIGN_POS, 16),  16'sd257, PREDICTED, '0, 1'b0);
      add_case(16'hFFFF, pack_sign_exp(SIGN_POS, 16),  16'sd514, PREDICTED, '0, 1'b0);
      // Fraction bits dropped at moderate negative shifts.
      add_case(16'hFFFF, pack_sign_exp(SIGN_NEG, -1),  -16'sd1,    PREDICTED, '0, 1'b0);
      add_case(16'h1234, pack_sign_exp(SIGN_POS, 0),   SCALE_MAX,  PREDICTED, '0, 1'b0);
      add_case(16'h5A3C, pack_sign_exp(SIGN_NEG, 12),  -16'sd12345, PREDICTED, '0, 1'b0);

      foreach (directed_cases[i]) begin
         want = directed_cases[i].typed ? directed_cases[i].want
                                        : scaled_int_of(directed_cases[i].stim);
         offer(directed_cases[i].stim, want);
         idle_sender(pick_gap());
      end
      drain_results();

      // Random transactions, with one long receiver hold-off, one full drain by the
      // sender and one stretch in which neither side idles.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         req_type item;
         if (n == HOLDOFF_AT) holdoff_request = 1'b1;
         if (n == PAUSE_AT) drain_results();
         quiet = (n >= QUIET_FROM && n < QUIET_TO);
         item = random_request();
         offer(item, scaled_int_of(item));
         idle_sender(pick_gap());
      end
      quiet = 1'b0;

      // Wait for the last results, then go on watching the output to catch any stray one.
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** float24_to_scaled_integer: PASSED **");
      end else begin
         $display("** float24_to_scaled_integer: FAILED **");
      end
      $finish;
   end

endmodule
